FILE: sv/lamp_pkg.sv
package lamp_pkg;

	localparam int YAW_BINS     = 361;
	localparam int ROW_STRIDE   = 384;
	localparam int BIT_LIMIT    = YAW_BINS * ROW_STRIDE;
	localparam int MASK_WORDS   = (BIT_LIMIT + 31) / 32;
	localparam int WORD_AW      = $clog2(MASK_WORDS);
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_W     = 48;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);

	localparam logic signed [31:0] DEG180  = 32'sd11796480;
	localparam logic [63:0]        NEAR_SQ = 64'd386547057;

	localparam logic [1:0] CMD_POINT = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [2:0] ST_KEPT    = 3'd0;
	localparam logic [2:0] ST_NEAR    = 3'd1;
	localparam logic [2:0] ST_MASKED  = 3'd2;
	localparam logic [2:0] ST_ADDRERR = 3'd3;
	localparam logic [2:0] ST_WORD    = 3'd4;

	localparam logic [2:0] REG_LEARN_MODE   = 3'd0;
	localparam logic [2:0] REG_LEARN_RADIUS = 3'd1;
	localparam logic [2:0] REG_Z_LOW        = 3'd2;
	localparam logic [2:0] REG_Z_HIGH       = 3'd3;
	localparam logic [2:0] REG_EXPAND       = 3'd4;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] x_coord;
		logic signed [31:0] y_coord;
		logic signed [31:0] z_coord;
		logic [15:0]        point_tag;
		logic [12:0]        word_addr;
		logic [31:0]        word_in;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] x_out;
		logic signed [31:0] y_out;
		logic signed [31:0] z_out;
		logic [15:0]        tag_out;
		logic [31:0]        word_out;
	} out_t;

	// atan(2^-i) in degrees scaled by 65536
	function automatic logic signed [31:0] lamp_atan(input logic [STEP_W-1:0] i);
		logic signed [31:0] v;
		case (i)
			4'd0:    v = 32'sd2949120;
			4'd1:    v = 32'sd1740967;
			4'd2:    v = 32'sd919879;
			4'd3:    v = 32'sd466945;
			4'd4:    v = 32'sd234379;
			4'd5:    v = 32'sd117304;
			4'd6:    v = 32'sd58666;
			4'd7:    v = 32'sd29335;
			4'd8:    v = 32'sd14668;
			4'd9:    v = 32'sd7334;
			4'd10:   v = 32'sd3667;
			4'd11:   v = 32'sd1833;
			4'd12:   v = 32'sd917;
			4'd13:   v = 32'sd458;
			4'd14:   v = 32'sd229;
			default: v = 32'sd115;
		endcase
		return v;
	endfunction

endpackage

FILE: sv/lidar_angular_mask_point_filter.sv
// Angular self-mask point filter. A filter request uses the shared 33x33
// multiplier for the squared distances and the squared learn radius, then the
// bit-pair square root, two runs of the 16-step CORDIC unit for yaw and pitch,
// then a mask read; a point that is too close leaves after the distance test.
// In learn mode a qualifying point first wraps its neighbourhood bins, then marks
// (2*expand_cells+1)^2 bins, each a read-modify-write on the single mask RAM
// port. A word write request finishes in the word state; a read adds a RAM read
// state. After reset the mask RAM is cleared one word per cycle, all 4332 words,
// with in_ready low; configuration writes are taken always.
module lidar_angular_mask_point_filter
	import lamp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_MX, S_MY, S_MZ, S_ML, S_NEAR, S_SQRT,
		S_CYGO, S_CYW, S_CPGO, S_CPW, S_BIN, S_WRAP, S_LRD, S_LWR,
		S_TRD, S_TCHK, S_WORD, S_WRD, S_DONE
	} state_t;

	state_t state_q;

	logic               learn_mode_q;
	logic [30:0]        learn_radius_q;
	logic signed [31:0] z_low_q, z_high_q;
	logic [3:0]         expand_q;

	in_t                item_q;
	out_t               res_q, out_q;
	logic               out_valid_q;
	logic               out_load;

	logic [WORD_AW-1:0] clr_q;
	logic [63:0]        prod_q, hsq_q, dsq_q;
	logic [63:0]        rem_q, root_q, bit_q;
	logic               lrn_q;
	logic signed [31:0] ty_q, tp_q;
	logic [19:0]        addr_q;
	logic signed [11:0] wy_q, wp_q, wp0_q;
	logic [4:0]         ci_q, cj_q;
	logic [WORD_AW-1:0] nword_q;
	logic [31:0]        nmask_q;

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [65:0] prod;

	always_comb begin
		case (state_q)
			S_MX:    mul_a = 33'(item_q.x_coord);
			S_MY:    mul_a = 33'(item_q.y_coord);
			S_MZ:    mul_a = 33'(item_q.z_coord);
			S_ML:    mul_a = {2'b00, learn_radius_q};
			default: mul_a = '0;
		endcase
		prod = mul_a * mul_a;
	end

	// square root step
	logic [63:0] trial;
	assign trial = root_q + bit_q;

	// cordic
	logic               cor_start, cor_done;
	logic signed [32:0] cor_px;
	logic signed [31:0] cor_py, cor_angle;

	always_comb begin
		cor_start = (state_q == S_CYGO) || (state_q == S_CPGO);
		if (state_q == S_CYGO) begin
			cor_px = 33'(item_q.x_coord);
			cor_py = item_q.y_coord;
		end else begin
			cor_px = {1'b0, root_q[31:0]};
			cor_py = item_q.z_coord;
		end
	end

	lamp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.px     (cor_px),
		.py     (cor_py),
		.done   (cor_done),
		.angle  (cor_angle)
	);

	// bin and address of the point
	logic [9:0]  iyaw, ipitch;
	logic [19:0] baddr;
	logic        bin_neg;

	always_comb begin
		iyaw    = ty_q[25:16];
		ipitch  = tp_q[25:16];
		bin_neg = ty_q[31] | tp_q[31];
		baddr   = 20'(iyaw) * 20'(ROW_STRIDE) + 20'(ipitch);
	end

	// neighbourhood bit address
	logic [17:0] nb;
	logic [4:0]  e2;
	logic        wy_ok, wp_ok;

	always_comb begin
		nb    = 18'(wy_q[8:0]) * 18'(ROW_STRIDE) + 18'(wp_q[8:0]);
		e2    = {expand_q, 1'b0};
		wy_ok = !wy_q[11] && (wy_q < 12'(YAW_BINS));
		wp_ok = !wp_q[11] && (wp_q < 12'(YAW_BINS));
	end

	function automatic logic signed [11:0] wrap_step(input logic signed [11:0] v);
		logic signed [11:0] r;
		if (v < 0) begin
			r = v + 12'(YAW_BINS);
		end else if (v >= 12'(YAW_BINS)) begin
			r = v - 12'(YAW_BINS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic signed [11:0] wrap_inc(input logic signed [11:0] v);
		return (v == 12'(YAW_BINS - 1)) ? 12'sd0 : v + 12'sd1;
	endfunction

	// mask RAM port
	logic               ram_we;
	logic [WORD_AW-1:0] ram_addr;
	logic [31:0]        ram_wdata, ram_rdata;
	logic               word_ok;

	assign word_ok = item_q.word_addr < 13'(MASK_WORDS);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = item_q.word_addr;
		ram_wdata = item_q.word_in;
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			S_LRD:   ram_addr = nb[17:5];
			S_LWR: begin
				ram_we    = 1'b1;
				ram_addr  = nword_q;
				ram_wdata = ram_rdata | nmask_q;
			end
			S_TRD:   ram_addr = addr_q[17:5];
			S_WORD:  ram_we = word_ok && (item_q.cmd == CMD_WRITE);
			default: ;
		endcase
	end

	lamp_ram #(
		.WIDTH (32),
		.DEPTH (MASK_WORDS)
	) u_mask (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_mode_q   <= 1'b0;
			learn_radius_q <= 31'd32768;
			z_low_q        <= 32'sd9830;
			z_high_q       <= 32'sd6553600;
			expand_q       <= 4'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LEARN_MODE:   learn_mode_q   <= cfg_data[0];
				REG_LEARN_RADIUS: learn_radius_q <= cfg_data[30:0];
				REG_Z_LOW:        z_low_q        <= cfg_data;
				REG_Z_HIGH:       z_high_q       <= cfg_data;
				REG_EXPAND:       expand_q       <= cfg_data[3:0];
				default:          ;
			endcase
		end
	end

	// load the output register when a result is ready and the register is free
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == WORD_AW'(MASK_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						if (in_data.cmd == CMD_POINT) begin
							res_q <= '{status: ST_KEPT, x_out: in_data.x_coord,
								y_out: in_data.y_coord, z_out: in_data.z_coord,
								tag_out: in_data.point_tag, word_out: '0};
							state_q <= S_MX;
						end else begin
							res_q   <= '0;
							state_q <= S_WORD;
						end
					end
				end
				S_MX: begin
					prod_q  <= prod[63:0];
					state_q <= S_MY;
				end
				S_MY: begin
					prod_q  <= prod[63:0];
					hsq_q   <= prod_q;
					state_q <= S_MZ;
				end
				S_MZ: begin
					prod_q  <= prod[63:0];
					hsq_q   <= hsq_q + prod_q;
					state_q <= S_ML;
				end
				S_ML: begin
					prod_q  <= prod[63:0];
					dsq_q   <= hsq_q + prod_q;
					state_q <= S_NEAR;
				end
				S_NEAR: begin
					lrn_q  <= learn_mode_q && (dsq_q < prod_q)
						&& (z_low_q < item_q.z_coord) && (item_q.z_coord < z_high_q);
					rem_q  <= hsq_q;
					root_q <= '0;
					bit_q  <= 64'h4000_0000_0000_0000;
					if (hsq_q < NEAR_SQ) begin
						res_q.status <= ST_NEAR;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (rem_q >= trial) begin
						rem_q  <= rem_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= S_CYGO;
					end
				end
				S_CYGO: state_q <= S_CYW;
				S_CYW: begin
					if (cor_done) begin
						ty_q    <= cor_angle + DEG180;
						state_q <= S_CPGO;
					end
				end
				S_CPGO: state_q <= S_CPW;
				S_CPW: begin
					if (cor_done) begin
						tp_q    <= cor_angle + DEG180;
						state_q <= S_BIN;
					end
				end
				S_BIN: begin
					addr_q <= baddr;
					wy_q   <= $signed({2'b00, iyaw}) - $signed({8'd0, expand_q});
					wp_q   <= $signed({2'b00, ipitch}) - $signed({8'd0, expand_q});
					ci_q   <= '0;
					cj_q   <= '0;
					if (bin_neg || baddr >= 20'(BIT_LIMIT)) begin
						res_q.status <= ST_ADDRERR;
						state_q      <= S_DONE;
					end else if (lrn_q) begin
						state_q <= S_WRAP;
					end else begin
						state_q <= S_TRD;
					end
				end
				S_WRAP: begin
					wy_q  <= wrap_step(wy_q);
					wp_q  <= wrap_step(wp_q);
					wp0_q <= wp_q;
					if (wy_ok && wp_ok) begin
						state_q <= S_LRD;
					end
				end
				S_LRD: begin
					nword_q <= nb[17:5];
					nmask_q <= 32'h8000_0000 >> nb[4:0];
					state_q <= S_LWR;
				end
				S_LWR: begin
					// advance across the neighbourhood, pitch fastest
					if (cj_q == e2) begin
						cj_q <= '0;
						wp_q <= wp0_q;
						if (ci_q == e2) begin
							state_q <= S_TRD;
						end else begin
							ci_q    <= ci_q + 1'b1;
							wy_q    <= wrap_inc(wy_q);
							state_q <= S_LRD;
						end
					end else begin
						cj_q    <= cj_q + 1'b1;
						wp_q    <= wrap_inc(wp_q);
						state_q <= S_LRD;
					end
				end
				S_TRD: state_q <= S_TCHK;
				S_TCHK: begin
					res_q.status <= ram_rdata[5'd31 - addr_q[4:0]] ? ST_MASKED : ST_KEPT;
					state_q      <= S_DONE;
				end
				S_WORD: begin
					res_q.status <= ST_WORD;
					state_q      <= S_DONE;
					case (item_q.cmd) inside
						CMD_WRITE, CMD_READ: begin
							if (!word_ok) begin
								res_q.status <= ST_ADDRERR;
							end else if (item_q.cmd == CMD_WRITE) begin
								res_q.word_out <= item_q.word_in;
							end else begin
								state_q <= S_WRD;
							end
						end
						default: ;
					endcase
				end
				S_WRD: begin
					res_q.word_out <= ram_rdata;
					state_q        <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: sv/lamp_ram.sv
module lamp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: sv/lamp_cordic.sv
module lamp_cordic
	import lamp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] px,
	input  logic signed [31:0] py,
	output logic               done,
	output logic signed [31:0] angle
);

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic signed [31:0]         acc_q;
	logic [STEP_W-1:0]          step_q;
	logic                       run_q;
	logic                       done_q;

	logic signed [CORDIC_W-1:0] xs, ys, dx, dy;
	logic signed [31:0]         at;

	always_comb begin
		xs = CORDIC_W'(px) <<< 8;
		ys = CORDIC_W'(py) <<< 8;
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		at = lamp_atan(step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
				// left half plane: flip into the right one and start at +/-180 deg
				if (xs < 0) begin
					x_q   <= -xs;
					y_q   <= -ys;
					acc_q <= (ys >= 0) ? DEG180 : -DEG180;
				end else begin
					x_q   <= xs;
					y_q   <= ys;
					acc_q <= '0;
				end
			end else if (run_q) begin
				if (y_q >= 0) begin
					x_q   <= x_q + dx;
					y_q   <= y_q - dy;
					acc_q <= acc_q + at;
				end else begin
					x_q   <= x_q - dx;
					y_q   <= y_q + dy;
					acc_q <= acc_q - at;
				end
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign angle = acc_q;

endmodule
